// ===== hdl/tdh_pkg.sv =====
// Shared types and constants for the timing-difference histogrammer.
package tdh_pkg;

  localparam int CFD_W       = 24;
  localparam int STAMP_W     = 20;
  localparam int STAMP_SHIFT = 4;
  localparam int DIFF_W      = CFD_W + 2;
  localparam int COUNT_W     = 32;
  localparam int PIN_W       = 64;
  localparam int PIN_SEL_W   = 6;
  localparam int BIN_IDX_W   = 15;
  localparam int POS_W       = 5;
  localparam int COL_W       = 2;

  localparam int OVERFLOW_BACKOFF = 1000;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_PIN_SELECT = 3'd0;

  localparam logic REQ_HIT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [1:0] {
    OP_DROP,
    OP_HIT,
    OP_READ,
    OP_READ_ZERO
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_WRITE,
    S_RESP
  } state_t;

endpackage

// ===== hdl/timing_difference_histogrammer.sv =====
// Top level of the timing-difference histogrammer: control, config port and output register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------------
//   request  | req_valid/req_ready  | req_type position column cfd_time stamp_low
//            |                      | event_ok clover_ok crystal_ok pin_pattern bin_index
//   response | rsp_valid/rsp_ready  | bin_count
//   config   | psel/penable/pwrite  | paddr pwdata prdata pready (pin_select at 0x0)
//
// A hit reads the entry and writes it back through the single memory port; the next
// request is taken in the write-back cycle. A valid read loads bin_count from a memory read.
// Rejected hits skip the memory; out-of-range reads return 0 without a memory read.
// After reset the memory is cleared one entry a cycle, NUM_POSITIONS*NUM_COLUMNS*NUM_BINS
// entries (2,228,224 at the defaults), with req_ready low.
// A result waiting on rsp_ready holds the next read's data in the memory output register.
module timing_difference_histogrammer import tdh_pkg::*; #(
  parameter int NUM_POSITIONS = 17,
  parameter int NUM_COLUMNS   = 4,
  parameter int NUM_BINS      = 32768
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic                 req_type,
  input  logic [POS_W-1:0]     position,
  input  logic [COL_W-1:0]     column,
  input  logic [CFD_W-1:0]     cfd_time,
  input  logic [STAMP_W-1:0]   stamp_low,
  input  logic                 event_ok,
  input  logic                 clover_ok,
  input  logic                 crystal_ok,
  input  logic [PIN_W-1:0]     pin_pattern,
  input  logic [BIN_IDX_W-1:0] bin_index,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output logic [COUNT_W-1:0]   bin_count,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int DEPTH  = NUM_POSITIONS * NUM_COLUMNS * NUM_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(NUM_POSITIONS * NUM_COLUMNS);
  localparam int BIN_W  = $clog2(NUM_BINS);

  state_t               state, state_next;
  logic [ADDR_W-1:0]    clr_addr;
  logic [PIN_SEL_W-1:0] pin_select;

  op_t                  dec_op;
  logic [ROW_W-1:0]     dec_row;
  logic [BIN_W-1:0]     dec_bin;
  op_t                  req_op;
  logic [ROW_W-1:0]     req_row;
  logic [BIN_W-1:0]     req_bin;
  logic [ADDR_W-1:0]    req_addr;

  logic                 ram_en;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [COUNT_W-1:0]   ram_wdata;
  logic [COUNT_W-1:0]   ram_rdata;

  logic                 req_xfer;
  logic                 rsp_free;
  logic                 rsp_load;
  logic                 clr_last;

  tdh_req_decode #(
    .NUM_POSITIONS(NUM_POSITIONS),
    .NUM_COLUMNS  (NUM_COLUMNS),
    .NUM_BINS     (NUM_BINS),
    .ROW_W        (ROW_W),
    .BIN_W        (BIN_W)
  ) u_decode (
    .req_type   (req_type),
    .position   (position),
    .column     (column),
    .cfd_time   (cfd_time),
    .stamp_low  (stamp_low),
    .event_ok   (event_ok),
    .clover_ok  (clover_ok),
    .crystal_ok (crystal_ok),
    .pin_pattern(pin_pattern),
    .bin_index  (bin_index),
    .pin_select (pin_select),
    .op         (dec_op),
    .row        (dec_row),
    .bin        (dec_bin)
  );

  tdh_spectrum_ram #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_PIN_SELECT) ? PDATA_W'(pin_select) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_select <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_PIN_SELECT)) begin
      pin_select <= pwdata[PIN_SEL_W-1:0];
    end
  end

  assign req_xfer = req_valid && req_ready;
  assign rsp_free = !rsp_valid || rsp_ready;
  assign clr_last = (clr_addr == ADDR_W'(DEPTH - 1));
  assign req_addr = ADDR_W'(32'(req_row) * NUM_BINS + 32'(req_bin));

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        state_next = (req_op == OP_HIT) ? S_WRITE : S_RESP;
      end
      S_IDLE, S_WRITE, S_RESP: begin
        if (state == S_RESP && !rsp_free) begin
          state_next = S_RESP;
        end else if (req_xfer) begin
          case (dec_op)
            OP_HIT, OP_READ: state_next = S_READ;
            OP_READ_ZERO:    state_next = S_RESP;
            default:         state_next = S_IDLE;
          endcase
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    rsp_load  = 1'b0;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = req_addr;
    ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
    case (state)
      S_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        req_ready = 1'b1;
      end
      S_READ: begin
        ram_en = 1'b1;
      end
      S_WRITE: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        req_ready = 1'b1;
      end
      S_RESP: begin
        rsp_load  = rsp_free;
        req_ready = rsp_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      req_op  <= dec_op;
      req_row <= dec_row;
      req_bin <= dec_bin;
    end
    if (rsp_load) begin
      bin_count <= (req_op == OP_READ_ZERO) ? '0 : ram_rdata;
    end
  end

  a_writeback_same_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> ($past(state) == S_READ && ram_addr == $past(ram_addr)))
    else $error("write-back does not target the entry just read");

  a_no_transfer_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req_xfer)
    else $error("request transfer during memory clear");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |-> !rsp_load)
    else $error("pending result overwritten");

  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && $past(state) == S_CLEAR && !$past(rst)) |->
    (clr_addr == $past(clr_addr) + 1'b1))
    else $error("clear sweep skipped an entry");

endmodule

// ===== hdl/tdh_req_decode.sv =====
// Request qualification, time difference and bin selection.
module tdh_req_decode import tdh_pkg::*; #(
  parameter int NUM_POSITIONS = 17,
  parameter int NUM_COLUMNS   = 4,
  parameter int NUM_BINS      = 32768,
  parameter int ROW_W         = $clog2(NUM_POSITIONS * NUM_COLUMNS),
  parameter int BIN_W         = $clog2(NUM_BINS)
) (
  input  logic                 req_type,
  input  logic [POS_W-1:0]     position,
  input  logic [COL_W-1:0]     column,
  input  logic [CFD_W-1:0]     cfd_time,
  input  logic [STAMP_W-1:0]   stamp_low,
  input  logic                 event_ok,
  input  logic                 clover_ok,
  input  logic                 crystal_ok,
  input  logic [PIN_W-1:0]     pin_pattern,
  input  logic [BIN_IDX_W-1:0] bin_index,
  input  logic [PIN_SEL_W-1:0] pin_select,
  output op_t                  op,
  output logic [ROW_W-1:0]     row,
  output logic [BIN_W-1:0]     bin
);

  localparam int HALF_BINS = NUM_BINS / 2;

  logic                addr_ok;
  logic                qualified;
  logic [CFD_W-1:0]    stamp_ref;
  logic [DIFF_W-1:0]   diff;
  logic [DIFF_W-4:0]   quot;
  logic                in_range;
  logic [BIN_W-1:0]    hit_bin;

  assign addr_ok = (32'(position) >= 1) && (32'(position) < NUM_POSITIONS) &&
                   (32'(column) < NUM_COLUMNS);

  assign qualified = event_ok && clover_ok && crystal_ok && pin_pattern[pin_select];

  assign stamp_ref = {stamp_low, {STAMP_SHIFT{1'b0}}};
  assign diff = {2'b00, cfd_time} - {2'b00, stamp_ref} + DIFF_W'(HALF_BINS);

  // negative differences truncate to zero or below, so they land in overflow
  assign quot     = diff[DIFF_W-2:2];
  assign in_range = !diff[DIFF_W-1] && (quot != '0) && (32'(quot) < NUM_BINS);
  assign hit_bin  = in_range ? quot[BIN_W-1:0] : BIN_W'(NUM_BINS - OVERFLOW_BACKOFF);

  assign row = ROW_W'(32'(position) * NUM_COLUMNS + 32'(column));

  always_comb begin
    op  = OP_DROP;
    bin = hit_bin;
    if (req_type == REQ_READ) begin
      bin = BIN_W'(bin_index);
      if (addr_ok && (32'(bin_index) < NUM_BINS)) begin
        op = OP_READ;
      end else begin
        op = OP_READ_ZERO;
      end
    end else if (addr_ok && qualified) begin
      op = OP_HIT;
    end
  end

endmodule

// ===== hdl/tdh_spectrum_ram.sv =====
// Single-port spectrum memory with registered read data.
module tdh_spectrum_ram import tdh_pkg::*; #(
  parameter int DEPTH  = 2228224,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               en,
  input  logic               we,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [COUNT_W-1:0] wdata,
  output logic [COUNT_W-1:0] rdata
);

  logic [COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench for the timing-difference histogrammer: random and directed hits and bin reads.
`timescale 1ns / 1ps

module tb;
  import tdh_pkg::*;

  localparam int NUM_POSITIONS = 17;
  localparam int NUM_COLUMNS   = 4;
  localparam int NUM_BINS      = 32768;
  localparam int TIME_DIV      = 4;
  localparam int OVERFLOW_BIN  = NUM_BINS - OVERFLOW_BACKOFF;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int RECENT_DEPTH  = 64;

  typedef struct {
    logic                 req_type;
    logic [POS_W-1:0]     position;
    logic [COL_W-1:0]     column;
    logic [CFD_W-1:0]     cfd_time;
    logic [STAMP_W-1:0]   stamp_low;
    logic                 event_ok;
    logic                 clover_ok;
    logic                 crystal_ok;
    logic [PIN_W-1:0]     pin_pattern;
    logic [BIN_IDX_W-1:0] bin_index;
  } hist_req_t;

  typedef struct {
    logic [POS_W-1:0]     position;
    logic [COL_W-1:0]     column;
    logic [BIN_IDX_W-1:0] bin;
  } bin_addr_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  logic                 req_type = REQ_HIT;
  logic [POS_W-1:0]     position = '0;
  logic [COL_W-1:0]     column = '0;
  logic [CFD_W-1:0]     cfd_time = '0;
  logic [STAMP_W-1:0]   stamp_low = '0;
  logic                 event_ok = 1'b0;
  logic                 clover_ok = 1'b0;
  logic                 crystal_ok = 1'b0;
  logic [PIN_W-1:0]     pin_pattern = '0;
  logic [BIN_IDX_W-1:0] bin_index = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  logic [COUNT_W-1:0]   bin_count;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  timing_difference_histogrammer #(
    .NUM_POSITIONS (NUM_POSITIONS),
    .NUM_COLUMNS   (NUM_COLUMNS),
    .NUM_BINS      (NUM_BINS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_type    (req_type),
    .position    (position),
    .column      (column),
    .cfd_time    (cfd_time),
    .stamp_low   (stamp_low),
    .event_ok    (event_ok),
    .clover_ok   (clover_ok),
    .crystal_ok  (crystal_ok),
    .pin_pattern (pin_pattern),
    .bin_index   (bin_index),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .bin_count   (bin_count),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  int unsigned           spectrum_count [int unsigned];
  logic [PIN_SEL_W-1:0]  pin_sel_model = '0;
  logic [COUNT_W-1:0]    expected_counts [$];
  bin_addr_t             counted_bins [$];

  int unsigned errors = 0;
  int unsigned n_requests = 0;
  int unsigned n_counted = 0;
  int unsigned n_overflow = 0;
  int unsigned n_reads_checked = 0;
  int unsigned n_pin_settings = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic bit addr_valid(logic [POS_W-1:0] pos, logic [COL_W-1:0] col);
    return pos >= 1 && pos < NUM_POSITIONS && col < NUM_COLUMNS;
  endfunction

  function automatic int unsigned bin_key(logic [POS_W-1:0] pos, logic [COL_W-1:0] col,
                                          int unsigned bin);
    return (int'(pos) * NUM_COLUMNS + int'(col)) * NUM_BINS + bin;
  endfunction

  function automatic int unsigned time_bin(logic [CFD_W-1:0] cfd, logic [STAMP_W-1:0] stamp);
    logic [CFD_W-1:0] stamp_ref;
    int               diff;
    int               t;
    stamp_ref = {stamp, {STAMP_SHIFT{1'b0}}};
    diff = int'({8'd0, cfd}) - int'({8'd0, stamp_ref}) + NUM_BINS / 2;
    t = diff / TIME_DIV;
    if (t > 0 && t < NUM_BINS) begin
      return t;
    end
    return OVERFLOW_BIN;
  endfunction

  task automatic predict_request(input hist_req_t r);
    int unsigned key;
    int unsigned bin;
    int unsigned cnt;
    n_requests++;
    if (r.req_type == REQ_READ) begin
      cnt = 0;
      if (addr_valid(r.position, r.column) && int'(r.bin_index) < NUM_BINS) begin
        key = bin_key(r.position, r.column, 32'(r.bin_index));
        if (spectrum_count.exists(key)) cnt = spectrum_count[key];
      end
      expected_counts.push_back(cnt);
    end else if (addr_valid(r.position, r.column) && r.event_ok && r.clover_ok &&
                 r.crystal_ok && r.pin_pattern[pin_sel_model]) begin
      bin = time_bin(r.cfd_time, r.stamp_low);
      key = bin_key(r.position, r.column, bin);
      if (!spectrum_count.exists(key)) spectrum_count[key] = 0;
      if (spectrum_count[key] != 32'hFFFF_FFFF) spectrum_count[key]++;
      n_counted++;
      if (bin == OVERFLOW_BIN) n_overflow++;
      counted_bins.push_back('{r.position, r.column, BIN_IDX_W'(bin)});
      if (counted_bins.size() > RECENT_DEPTH) void'(counted_bins.pop_front());
    end
  endtask

  task automatic send_item(input hist_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid   <= 1'b1;
    req_type    <= r.req_type;
    position    <= r.position;
    column      <= r.column;
    cfd_time    <= r.cfd_time;
    stamp_low   <= r.stamp_low;
    event_ok    <= r.event_ok;
    clover_ok   <= r.clover_ok;
    crystal_ok  <= r.crystal_ok;
    pin_pattern <= r.pin_pattern;
    bin_index   <= r.bin_index;
    do @(posedge clk); while (!req_ready);
    predict_request(r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    req_valid <= 1'b0;
    while (expected_counts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_pin_select(input logic [PIN_SEL_W-1:0] sel);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_PIN_SELECT;
    pwdata  <= PDATA_W'(sel);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pin_sel_model = sel;
    n_pin_settings++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(sel)) begin
      errors++;
      $display("%0t: pin_select readback expected %0d actual %0d", $time, sel, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic hist_req_t make_hit(logic [POS_W-1:0] pos, logic [COL_W-1:0] col,
                                         logic [CFD_W-1:0] cfd, logic [STAMP_W-1:0] stamp);
    hist_req_t r;
    r = '{REQ_HIT, pos, col, cfd, stamp, 1'b1, 1'b1, 1'b1, '1, '0};
    return r;
  endfunction

  function automatic hist_req_t make_read(logic [POS_W-1:0] pos, logic [COL_W-1:0] col,
                                          int unsigned bin);
    hist_req_t r;
    r = '{REQ_READ, pos, col, '0, '0, 1'b0, 1'b0, 1'b0, '0, BIN_IDX_W'(bin)};
    return r;
  endfunction

  function automatic hist_req_t random_request();
    hist_req_t        r;
    int unsigned      pick;
    int               offset;
    logic [CFD_W-1:0] stamp_ref;
    bin_addr_t        a;
    pick          = $urandom_range(99);
    r.req_type    = REQ_HIT;
    r.position    = POS_W'($urandom);
    r.column      = COL_W'($urandom);
    r.cfd_time    = CFD_W'($urandom);
    r.stamp_low   = STAMP_W'($urandom);
    r.event_ok    = 1'($urandom);
    r.clover_ok   = 1'($urandom);
    r.crystal_ok  = 1'($urandom);
    r.pin_pattern = {$urandom, $urandom};
    r.bin_index   = BIN_IDX_W'($urandom);
    if (pick < 65) begin
      r.position   = POS_W'($urandom_range(1, NUM_POSITIONS - 1));
      r.event_ok   = 1'b1;
      r.clover_ok  = 1'b1;
      r.crystal_ok = 1'b1;
      r.pin_pattern[pin_sel_model] = 1'b1;
      if ($urandom_range(9) != 0) begin
        stamp_ref  = {r.stamp_low, {STAMP_SHIFT{1'b0}}};
        offset     = int'($urandom_range(0, 4 * NUM_BINS + 20)) - (NUM_BINS / 2 + 16);
        r.cfd_time = stamp_ref + CFD_W'(offset);
      end
    end else if (pick < 90) begin
      r.req_type = REQ_READ;
      if (counted_bins.size() != 0 && $urandom_range(4) != 0) begin
        a           = counted_bins[$urandom_range(counted_bins.size() - 1)];
        r.position  = a.position;
        r.column    = a.column;
        r.bin_index = a.bin;
      end
    end
    return r;
  endfunction

  task automatic test_directed();
    hist_req_t r;
    send_item(make_hit(1, 0, 4, 1024));
    send_item(make_hit(1, 0, 3, 1024));
    send_item(make_hit(16, 3, 114684, 0));
    send_item(make_hit(16, 3, 114688, 0));
    send_item(make_hit(2, 1, '1, '1));
    send_item(make_hit(2, 1, '0, '1));
    send_item(make_hit(3, 2, 13, 1025));
    r = make_hit(1, 0, 4, 1024);
    r.event_ok = 1'b0;
    send_item(r);
    r = make_hit(1, 0, 4, 1024);
    r.clover_ok = 1'b0;
    send_item(r);
    r = make_hit(1, 0, 4, 1024);
    r.crystal_ok = 1'b0;
    send_item(r);
    r = make_hit(1, 0, 4, 1024);
    r.pin_pattern = ~(PIN_W'(1) << pin_sel_model);
    send_item(r);
    send_item(make_hit(0, 0, 4, 1024));
    send_item(make_hit(NUM_POSITIONS, 1, 4, 1024));
    send_item(make_hit('1, 3, 4, 1024));
    send_item(make_hit(1, 0, 5, 1024));
    send_item(make_read(1, 0, 1));
    send_item(make_read(1, 0, 0));
    send_item(make_read(1, 0, OVERFLOW_BIN));
    send_item(make_read(16, 3, NUM_BINS - 1));
    send_item(make_read(16, 3, OVERFLOW_BIN));
    send_item(make_read(2, 1, 4099));
    send_item(make_read(2, 1, OVERFLOW_BIN));
    send_item(make_read(3, 2, OVERFLOW_BIN));
    send_item(make_read(0, 0, 1));
    send_item(make_read('1, 3, NUM_BINS - 1));
    wait_drained();
  endtask

  task automatic test_pin_extremes();
    hist_req_t r;
    set_pin_select('1);
    r = make_hit(5, 0, 16, 0);
    r.pin_pattern = PIN_W'(1) << (PIN_W - 1);
    send_item(r);
    r.pin_pattern = ~r.pin_pattern;
    send_item(r);
    send_item(make_read(5, 0, time_bin(16, 0)));
    wait_drained();
    set_pin_select('0);
    r.pin_pattern = PIN_W'(1);
    send_item(r);
    r.pin_pattern = ~r.pin_pattern;
    send_item(r);
    send_item(make_read(5, 0, time_bin(16, 0)));
    wait_drained();
  endtask

  task automatic test_random_phase(input int unsigned n, input int unsigned idle,
                                   input int unsigned stall, input logic [PIN_SEL_W-1:0] sel);
    set_pin_select(sel);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (n) send_item(random_request());
    wait_drained();
  endtask

  task automatic test_backpressure();
    hist_req_t r;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 400;
    repeat (40) begin
      r = random_request();
      r.req_type = REQ_READ;
      send_item(r);
    end
    wait_drained();
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_counts.size() == 0) begin
        errors++;
        $display("%0t: bin_count expected none actual %0d", $time, bin_count);
      end else begin
        if (bin_count !== expected_counts[0]) begin
          errors++;
          $display("%0t: bin_count expected %0d actual %0d", $time, expected_counts[0],
                   bin_count);
        end
        void'(expected_counts.pop_front());
        n_reads_checked++;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_pin_extremes();
    test_random_phase(350, 0, 0, 0);
    test_random_phase(300, 80, 0, '1);
    test_backpressure();
    test_random_phase(300, 0, 80, 37);
    test_random_phase(300, 25, 25, PIN_SEL_W'($urandom_range(1, 62)));
    if (expected_counts.size() != 0) begin
      errors++;
      $display("%0t: bin_count expected %0d actual none (%0d left)", $time,
               expected_counts[0], expected_counts.size());
    end
    $display("Run covered %0d requests: %0d hits counted (%0d to the overflow bin), %0d reads",
             n_requests, n_counted, n_overflow, n_reads_checked);
    $display("under %0d pin_select settings and four idle and stall mixes, one long hold-off",
             n_pin_settings);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== timing_difference_histogrammer.f =====
hdl/tdh_pkg.sv
hdl/tdh_req_decode.sv
hdl/tdh_spectrum_ram.sv
hdl/timing_difference_histogrammer.sv
tb/tb.sv
